// ===== rtl/core/okvl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvl_pkg: shared definitions for the ordered key/datum list
// Sizes, request codes, result status codes and the per-cell control word.
// ----------------------------------------------------------------------------
package okvl_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 32;
  localparam int DATUM_BITS = 32;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int REQ_W      = 4;
  localparam int POS_W      = 4;
  localparam int ENTRY_W    = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_FIND       = 4'd0,
    REQ_HAS_DATUM  = 4'd1,
    REQ_ADD_FRONT  = 4'd2,
    REQ_ADD_BACK   = 4'd3,
    REQ_ADD_UNIQUE = 4'd4,
    REQ_REMOVE     = 4'd5,
    REQ_POP        = 4'd6,
    REQ_PEEK       = 4'd7,
    REQ_READ_POS   = 4'd8
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_NEW,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     live;
    logic     capture;
  } cell_ctl_t;

endpackage

// ===== rtl/core/okvl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvl_cell: one slot of the ordered list
// Holds a key/datum pair, compares it against the incoming request and
// shifts toward either neighbor on insert or removal.
// ----------------------------------------------------------------------------
module okvl_cell (
  input  logic                          clk,
  input  okvl_pkg::cell_ctl_t           ctl,
  input  logic [okvl_pkg::KEY_BITS-1:0]   cmp_key,
  input  logic [okvl_pkg::DATUM_BITS-1:0] cmp_datum,
  input  logic [okvl_pkg::KEY_BITS-1:0]   new_key,
  input  logic [okvl_pkg::DATUM_BITS-1:0] new_datum,
  input  logic [okvl_pkg::KEY_BITS-1:0]   left_key,
  input  logic [okvl_pkg::DATUM_BITS-1:0] left_datum,
  input  logic [okvl_pkg::KEY_BITS-1:0]   right_key,
  input  logic [okvl_pkg::DATUM_BITS-1:0] right_datum,
  output logic [okvl_pkg::KEY_BITS-1:0]   key_r,
  output logic [okvl_pkg::DATUM_BITS-1:0] datum_r,
  output logic                          key_match_r,
  output logic                          datum_match_r
);
  import okvl_pkg::*;

  logic [KEY_BITS-1:0]   key_nxt;
  logic [DATUM_BITS-1:0] datum_nxt;

  always_comb begin
    case (ctl.op)
      CELL_LOAD_NEW: begin
        key_nxt   = new_key;
        datum_nxt = new_datum;
      end
      CELL_FROM_LEFT: begin
        key_nxt   = left_key;
        datum_nxt = left_datum;
      end
      CELL_FROM_RIGHT: begin
        key_nxt   = right_key;
        datum_nxt = right_datum;
      end
      default: begin
        key_nxt   = key_r;
        datum_nxt = datum_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    datum_r <= datum_nxt;
    if (ctl.capture) begin
      key_match_r   <= ctl.live && (key_r == cmp_key);
      datum_match_r <= ctl.live && (datum_r == cmp_datum);
    end
  end

endmodule

// ===== rtl/core/ordered_key_value_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_value_list: bounded ordered key/datum store
// Timing: match flags are taken at the input transfer, and the result is
// registered when S_EXEC commits, once the output slot is free or taken.
// Flow: in_stall holds off requests in S_EXEC; the next request is taken
// while a finished result still waits on out_stall.
// Reset: fill count cleared, store empty; slot contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_key_value_list (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [okvl_pkg::REQ_W-1:0]      in_req_type,
  input  logic [okvl_pkg::KEY_BITS-1:0]   in_key_in,
  input  logic [okvl_pkg::DATUM_BITS-1:0] in_datum_in,
  input  logic [okvl_pkg::POS_W-1:0]      in_position,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [1:0]                      out_status,
  output logic [okvl_pkg::KEY_BITS-1:0]   out_key,
  output logic [okvl_pkg::DATUM_BITS-1:0] out_datum,
  output logic [okvl_pkg::ENTRY_W-1:0]    out_entry_count
);
  import okvl_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  localparam logic [CAPACITY-1:0] ONE_V = CAPACITY'(1);

  state_t                state_r;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [REQ_W-1:0]      req_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [DATUM_BITS-1:0] datum_r;
  logic [POS_W-1:0]      pos_r;

  logic                  out_valid_r;
  logic                  out_hit_r, out_hit_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [KEY_BITS-1:0]   out_key_r, out_key_nxt;
  logic [DATUM_BITS-1:0] out_datum_r, out_datum_nxt;
  logic [ENTRY_W-1:0]    out_entry_count_r;

  logic accept, commit, full, nonempty;

  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [DATUM_BITS-1:0] cell_datum [CAPACITY];
  logic [CAPACITY-1:0]   key_match, datum_match, live;
  logic [CAPACITY-1:0]   key_first, from_at, pos_sel, sel;
  cell_ctl_t             ctl [CAPACITY];
  logic                  key_any;
  logic [KEY_BITS-1:0]   rd_key;
  logic [DATUM_BITS-1:0] rd_datum;

  assign in_stall = (state_r == S_EXEC);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign full     = (int'(count_r) >= CAPACITY);
  assign nonempty = (count_r != '0);

  assign key_first = key_match & (-key_match);
  assign key_any   = |key_match;
  assign from_at   = ~(key_first - ONE_V);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i]    = (int'(count_r) > i);
      pos_sel[i] = (int'(pos_r) == i);
    end
  end

  // per-cell shift control
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].live    = live[i];
      ctl[i].capture = accept;
      ctl[i].op      = CELL_HOLD;
      if (commit) begin
        case (req_r)
          REQ_ADD_FRONT: begin
            if (!full) ctl[i].op = (i == 0) ? CELL_LOAD_NEW : CELL_FROM_LEFT;
          end
          REQ_ADD_UNIQUE: begin
            if (!full && !key_any) ctl[i].op = (i == 0) ? CELL_LOAD_NEW : CELL_FROM_LEFT;
          end
          REQ_ADD_BACK: begin
            if (!full && int'(count_r) == i) ctl[i].op = CELL_LOAD_NEW;
          end
          REQ_REMOVE: begin
            if (from_at[i]) ctl[i].op = CELL_FROM_RIGHT;
          end
          REQ_POP: begin
            if (nonempty) ctl[i].op = CELL_FROM_RIGHT;
          end
          default: ctl[i].op = CELL_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    okvl_cell u_cell (
      .clk           (clk),
      .ctl           (ctl[g]),
      .cmp_key       (in_key_in),
      .cmp_datum     (in_datum_in),
      .new_key       (key_r),
      .new_datum     (datum_r),
      .left_key      (cell_key[(g == 0) ? 0 : g - 1]),
      .left_datum    (cell_datum[(g == 0) ? 0 : g - 1]),
      .right_key     (cell_key[(g == CAPACITY - 1) ? g : g + 1]),
      .right_datum   (cell_datum[(g == CAPACITY - 1) ? g : g + 1]),
      .key_r         (cell_key[g]),
      .datum_r       (cell_datum[g]),
      .key_match_r   (key_match[g]),
      .datum_match_r (datum_match[g])
    );
  end

  // one-hot readout
  always_comb begin
    case (req_r)
      REQ_FIND, REQ_ADD_UNIQUE, REQ_REMOVE: sel = key_first;
      REQ_POP, REQ_PEEK:                    sel = nonempty ? ONE_V : '0;
      REQ_READ_POS:                         sel = pos_sel & live;
      default:                              sel = '0;
    endcase
    rd_key   = '0;
    rd_datum = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel[i]) begin
        rd_key   = rd_key | cell_key[i];
        rd_datum = rd_datum | cell_datum[i];
      end
    end
  end

  always_comb begin
    out_hit_nxt    = 1'b0;
    out_status_nxt = ST_MISS;
    out_key_nxt    = '0;
    out_datum_nxt  = '0;
    count_nxt      = count_r;
    case (req_r)
      REQ_FIND: begin
        if (key_any) begin
          out_hit_nxt    = 1'b1;
          out_status_nxt = ST_OK;
          out_datum_nxt  = rd_datum;
        end
      end
      REQ_HAS_DATUM: begin
        if (|datum_match) begin
          out_hit_nxt    = 1'b1;
          out_status_nxt = ST_OK;
        end
      end
      REQ_ADD_FRONT, REQ_ADD_BACK: begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          out_hit_nxt    = 1'b1;
          out_status_nxt = ST_OK;
          count_nxt      = count_r + 1'b1;
        end
      end
      REQ_ADD_UNIQUE: begin
        if (key_any) begin
          out_status_nxt = ST_OK;
          out_datum_nxt  = rd_datum;
        end else if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          out_hit_nxt    = 1'b1;
          out_status_nxt = ST_OK;
          out_datum_nxt  = datum_r;
          count_nxt      = count_r + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (key_any) begin
          out_hit_nxt    = 1'b1;
          out_status_nxt = ST_OK;
          out_datum_nxt  = rd_datum;
          count_nxt      = count_r - 1'b1;
        end
      end
      REQ_POP: begin
        if (nonempty) begin
          out_hit_nxt    = 1'b1;
          out_status_nxt = ST_OK;
          out_key_nxt    = rd_key;
          out_datum_nxt  = rd_datum;
          count_nxt      = count_r - 1'b1;
        end
      end
      REQ_PEEK, REQ_READ_POS: begin
        if (|sel) begin
          out_hit_nxt    = 1'b1;
          out_status_nxt = ST_OK;
          out_key_nxt    = rd_key;
          out_datum_nxt  = rd_datum;
        end
      end
      default: out_status_nxt = ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r       <= 1'b1;
        out_hit_r         <= out_hit_nxt;
        out_status_r      <= out_status_nxt;
        out_key_r         <= out_key_nxt;
        out_datum_r       <= out_datum_nxt;
        out_entry_count_r <= ENTRY_W'(count_nxt);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (commit) begin
            state_r <= S_IDLE;
            count_r <= count_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      key_r   <= in_key_in;
      datum_r <= in_datum_in;
      pos_r   <= in_position;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_status      = out_status_r;
  assign out_key         = out_key_r;
  assign out_datum       = out_datum_r;
  assign out_entry_count = out_entry_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= CAPACITY)
    else $error("fill count above capacity");

  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(key_first))
    else $error("first key match not one-hot");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && req_r == REQ_POP && nonempty) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not shrink the list");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (out_status_r == ST_OK))
    else $error("hit reported with error status");

  a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && full) |=> (count_r <= $past(count_r)))
    else $error("full list grew");

endmodule

// ===== test/ordered_key_value_list_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_value_list_tb: self-checking testbench for the ordered key list
// Sends find, presence, add, remove, pop, peek and position-read requests.
// A local copy of the list predicts every result, and the results are
// checked in order, field by field. Random idle bursts on both channels.
// One long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module ordered_key_value_list_tb;
  import okvl_pkg::*;

  typedef struct {
    logic                  hit;
    logic [1:0]            status;
    logic [KEY_BITS-1:0]   key;
    logic [DATUM_BITS-1:0] datum;
    logic [ENTRY_W-1:0]    count;
  } list_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [REQ_W-1:0]      in_req_type;
  logic [KEY_BITS-1:0]   in_key_in;
  logic [DATUM_BITS-1:0] in_datum_in;
  logic [POS_W-1:0]      in_position;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_hit;
  logic [1:0]            out_status;
  logic [KEY_BITS-1:0]   out_key;
  logic [DATUM_BITS-1:0] out_datum;
  logic [ENTRY_W-1:0]    out_entry_count;

  logic [KEY_BITS-1:0]   list_keys   [CAPACITY];
  logic [DATUM_BITS-1:0] list_datums [CAPACITY];
  int                    list_fill = 0;
  list_result_t          pending_results [$];
  list_result_t          want;
  logic [KEY_BITS-1:0]   key_pool [8];
  int                    mismatches = 0;
  bit                    quiet = 0;
  bit                    hold_req = 0;
  int                    hold_left;
  int                    burst_left;

  ordered_key_value_list u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_key_in      (in_key_in),
    .in_datum_in    (in_datum_in),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_status     (out_status),
    .out_key        (out_key),
    .out_datum      (out_datum),
    .out_entry_count(out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    out_stall  = 1'b0;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall = 1'b1;
        burst_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall  = 1'b1;
        burst_left = $urandom_range(0, 15);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result transfer with nothing pending at %0t", $time);
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit || out_status !== want.status ||
            out_key !== want.key || out_datum !== want.datum ||
            out_entry_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: mismatch at %0t: expected hit %0b status %0d key %h ",
                      "datum %h count %0d, got hit %0b status %0d key %h datum %h ",
                      "count %0d"}, $time, want.hit, want.status, want.key,
                     want.datum, want.count, out_hit, out_status, out_key,
                     out_datum, out_entry_count);
        end
      end
    end
  end

  function automatic int first_key_at(input logic [KEY_BITS-1:0] k);
    for (int i = 0; i < list_fill; i++)
      if (list_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic void insert_front(input logic [KEY_BITS-1:0] k,
                                       input logic [DATUM_BITS-1:0] d);
    for (int i = list_fill; i > 0; i--) begin
      list_keys[i]   = list_keys[i-1];
      list_datums[i] = list_datums[i-1];
    end
    list_keys[0]   = k;
    list_datums[0] = d;
    list_fill++;
  endfunction

  function automatic void drop_at(input int at);
    for (int i = at; i + 1 < list_fill; i++) begin
      list_keys[i]   = list_keys[i+1];
      list_datums[i] = list_datums[i+1];
    end
    list_fill--;
  endfunction

  // updates the local list and queues the result one request should give
  function automatic void apply_request(input logic [REQ_W-1:0] req,
                                        input logic [KEY_BITS-1:0] k,
                                        input logic [DATUM_BITS-1:0] d,
                                        input logic [POS_W-1:0] pos);
    list_result_t r;
    int           at;
    bit           full;
    r.hit    = 1'b0;
    r.status = ST_MISS;
    r.key    = '0;
    r.datum  = '0;
    full     = list_fill >= CAPACITY;
    at       = first_key_at(k);
    case (req)
      REQ_FIND: begin
        if (at >= 0) begin
          r.hit    = 1'b1;
          r.status = ST_OK;
          r.datum  = list_datums[at];
        end
      end
      REQ_HAS_DATUM: begin
        for (int i = 0; i < list_fill; i++)
          if (list_datums[i] == d) begin
            r.hit    = 1'b1;
            r.status = ST_OK;
          end
      end
      REQ_ADD_FRONT: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          insert_front(k, d);
          r.hit    = 1'b1;
          r.status = ST_OK;
        end
      end
      REQ_ADD_BACK: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          list_keys[list_fill]   = k;
          list_datums[list_fill] = d;
          list_fill++;
          r.hit    = 1'b1;
          r.status = ST_OK;
        end
      end
      REQ_ADD_UNIQUE: begin
        if (at >= 0) begin
          r.status = ST_OK;
          r.datum  = list_datums[at];
        end else if (full) begin
          r.status = ST_FULL;
        end else begin
          insert_front(k, d);
          r.hit    = 1'b1;
          r.status = ST_OK;
          r.datum  = d;
        end
      end
      REQ_REMOVE: begin
        if (at >= 0) begin
          r.datum = list_datums[at];
          drop_at(at);
          r.hit    = 1'b1;
          r.status = ST_OK;
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (list_fill > 0) begin
          r.key   = list_keys[0];
          r.datum = list_datums[0];
          if (req == REQ_POP) drop_at(0);
          r.hit    = 1'b1;
          r.status = ST_OK;
        end
      end
      REQ_READ_POS: begin
        if (int'(pos) < list_fill) begin
          r.key    = list_keys[pos];
          r.datum  = list_datums[pos];
          r.hit    = 1'b1;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.count = ENTRY_W'(list_fill);
    pending_results.push_back(r);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic [KEY_BITS-1:0] k,
                              input logic [DATUM_BITS-1:0] d,
                              input logic [POS_W-1:0] pos);
    in_valid    = 1'b1;
    in_req_type = req;
    in_key_in   = k;
    in_datum_in = d;
    in_position = pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(req, k, d, pos);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic finish_results();
    in_valid = 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && list_fill > 0) return list_keys[$urandom_range(0, list_fill - 1)];
    if (r < 8) return key_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic logic [DATUM_BITS-1:0] pick_datum();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATUM_BITS-1:0] pick_stored_datum();
    if (list_fill > 0 && $urandom_range(0, 2) != 0)
      return list_datums[$urandom_range(0, list_fill - 1)];
    return pick_datum();
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 15));
    return POS_W'($urandom_range(0, (list_fill > 15) ? 15 : list_fill));
  endfunction

  task automatic random_request();
    int               r;
    logic [REQ_W-1:0] req;
    r = $urandom_range(0, 99);
    if (r < 4)       req = REQ_W'($urandom_range(9, 15));
    else if (r < 16) req = REQ_FIND;
    else if (r < 26) req = REQ_HAS_DATUM;
    else if (r < 38) req = REQ_ADD_FRONT;
    else if (r < 50) req = REQ_ADD_BACK;
    else if (r < 62) req = REQ_ADD_UNIQUE;
    else if (r < 74) req = REQ_REMOVE;
    else if (r < 82) req = REQ_POP;
    else if (r < 88) req = REQ_PEEK;
    else             req = REQ_READ_POS;
    send_request(req, pick_key(),
                 (req == REQ_HAS_DATUM) ? pick_stored_datum() : pick_datum(),
                 pick_position());
  endtask

  // empty-list misses, extreme values, duplicate keys and unused codes
  task automatic test_directed();
    send_request(REQ_POP,        '0,           '0,           4'd0);
    send_request(REQ_PEEK,       '0,           '0,           4'd0);
    send_request(REQ_FIND,       '0,           '0,           4'd0);
    send_request(REQ_REMOVE,     '1,           '0,           4'd0);
    send_request(REQ_HAS_DATUM,  '0,           '0,           4'd0);
    send_request(REQ_READ_POS,   '0,           '0,           4'd0);
    send_request(REQ_W'(15),     '1,           '1,           4'd15);
    send_request(REQ_ADD_BACK,   '1,           '0,           4'd0);
    send_request(REQ_ADD_FRONT,  '0,           '1,           4'd15);
    send_request(REQ_ADD_UNIQUE, '0,           32'h1234_5678, 4'd0);
    send_request(REQ_ADD_UNIQUE, 32'h5A5A_A5A5, 32'hC3C3_3C3C, 4'd0);
    send_request(REQ_FIND,       '1,           '0,           4'd0);
    send_request(REQ_HAS_DATUM,  '0,           '1,           4'd0);
    send_request(REQ_READ_POS,   '0,           '0,           4'd2);
    send_request(REQ_READ_POS,   '0,           '0,           4'd15);
    send_request(REQ_PEEK,       '0,           '0,           4'd0);
    send_request(REQ_REMOVE,     '0,           '0,           4'd0);
    send_request(REQ_POP,        '0,           '0,           4'd0);
    send_request(REQ_ADD_FRONT,  '1,           32'hA5A5_5A5A, 4'd0);
    send_request(REQ_FIND,       '1,           '0,           4'd0);
    send_request(REQ_W'(9),      '0,           '0,           4'd7);
  endtask

  // fill to capacity, hit the full-list errors, read every slot, drain
  task automatic test_fill_and_empty();
    logic [REQ_W-1:0] req;
    repeat (2) begin
      while (list_fill < CAPACITY) begin
        case ($urandom_range(0, 2))
          0:       req = REQ_ADD_FRONT;
          1:       req = REQ_ADD_BACK;
          default: req = REQ_ADD_UNIQUE;
        endcase
        send_request(req, pick_key(), pick_datum(), pick_position());
      end
      send_request(REQ_ADD_FRONT, pick_key(), pick_datum(), 4'd0);
      send_request(REQ_ADD_BACK, pick_key(), pick_datum(), 4'd0);
      send_request(REQ_ADD_UNIQUE, $urandom(), pick_datum(), 4'd0);
      send_request(REQ_ADD_UNIQUE, list_keys[$urandom_range(0, CAPACITY - 1)],
                   pick_datum(), 4'd0);
      for (int p = 0; p < 16; p++)
        send_request(REQ_READ_POS, pick_key(), pick_datum(), POS_W'(p));
      while (list_fill > 0) begin
        case ($urandom_range(0, 3))
          0:       req = REQ_POP;
          1:       req = REQ_PEEK;
          default: req = REQ_REMOVE;
        endcase
        send_request(req, list_keys[$urandom_range(0, list_fill - 1)],
                     pick_stored_datum(), pick_position());
      end
    end
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (14) random_request();
    finish_results();
  endtask

  task automatic test_random_mix(input int n);
    repeat (n) random_request();
    finish_results();
  endtask

  task automatic test_streaming();
    quiet = 1'b1;
    repeat (60) random_request();
    finish_results();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = '0;
    in_key_in   = '0;
    in_datum_in = '0;
    in_position = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    finish_results();
    test_fill_and_empty();
    finish_results();
    test_backpressure();
    test_random_mix(130);
    test_random_mix(130);
    test_streaming();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
